FILE: rtl/mhl_pkg.sv
// Shared types, step tables and character codes for the Maidenhead locator pipeline.
// No dependencies; every other file imports this package.
package mhl_pkg;

  localparam int NUM_PAIRS = 5;
  localparam int MAX_MULT  = 23;

  typedef logic [2:0]  pair_idx_t;
  typedef logic [29:0] coord_t;
  typedef logic [6:0]  char_t;
  typedef logic [4:0]  quot_t;

  typedef logic [MAX_MULT-1:0][31:0] mul_row_t;

  localparam logic signed [31:0] LAT_LIMIT = 32'sd216000000;
  localparam logic signed [31:0] LON_LIMIT = 32'sd432000000;

  localparam char_t CHAR_A       = 7'd65;
  localparam char_t CHAR_0       = 7'd48;
  localparam quot_t LETTER_MAX_Q = 5'd23;
  localparam quot_t DIGIT_MAX_Q  = 5'd9;

  // Bit i set where pair i is encoded as a letter rather than a digit.
  localparam logic [NUM_PAIRS-1:0] PAIR_IS_LETTER = 5'b00101;

  // Multiples 1..MAX_MULT of one step, worked out at elaboration.
  function automatic mul_row_t multiples(input logic [31:0] step);
    mul_row_t row;
    for (int k = 0; k < MAX_MULT; k++) begin
      row[k] = 32'(step * 32'(k + 1));
    end
    return row;
  endfunction

  localparam mul_row_t LON_MUL [NUM_PAIRS] = '{
    multiples(32'd48000000), multiples(32'd4800000), multiples(32'd200000),
    multiples(32'd20000), multiples(32'd2000)
  };
  localparam mul_row_t LAT_MUL [NUM_PAIRS] = '{
    multiples(32'd24000000), multiples(32'd2400000), multiples(32'd100000),
    multiples(32'd10000), multiples(32'd1000)
  };

  typedef struct packed {
    coord_t                          lon;
    coord_t                          lat;
    logic [2*NUM_PAIRS-1:0][6:0]     chars;
  } pipe_t;

endpackage

FILE: rtl/maidenhead_locator_10.sv
// Top level: 10-character Maidenhead locator from a fixed-point position.
// Throughput: one position per cycle unless out_ready_i stalls it; one register stage
// saturates and offsets, then one stage per character pair divides by that pair's step
// via parallel compares.
// Each stage stalls only when it is full and the one after it cannot take its beat.
// Reset (rst_ni low, asynchronous) clears every stage's valid bit; payload is not reset.
// Depends on mhl_pkg and mhl_pair_div.
module maidenhead_locator_10 import mhl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [28:0] latitude_i,
  input  logic [29:0] longitude_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_field_lon_o,
  output logic [6:0]  char_field_lat_o,
  output logic [5:0]  char_square_lon_o,
  output logic [5:0]  char_square_lat_o,
  output logic [6:0]  char_subsq_lon_o,
  output logic [6:0]  char_subsq_lat_o,
  output logic [5:0]  char_ext_lon_o,
  output logic [5:0]  char_ext_lat_o,
  output logic [5:0]  char_fine_lon_o,
  output logic [5:0]  char_fine_lat_o
);

  logic [NUM_PAIRS:0]   valid_q;
  logic [NUM_PAIRS+1:0] rdy;
  pipe_t                pipe_q [NUM_PAIRS+1];
  pipe_t                pipe_d [NUM_PAIRS+1];

  logic signed [31:0] lat_x, lon_x, lat_c, lon_c, lat_sum, lon_sum;

  // A stage can take a beat when it is empty or its own beat moves on this cycle.
  assign rdy[NUM_PAIRS+1] = out_ready_i;
  for (genvar g = 0; g <= NUM_PAIRS; g++) begin : g_rdy
    assign rdy[g] = !valid_q[g] || rdy[g+1];
  end
  assign in_ready_o = rdy[0];

  // Stage 0: saturate to the legal range and offset so both coordinates are non-negative.
  always_comb begin
    lat_x = 32'(signed'(latitude_i));
    lon_x = 32'(signed'(longitude_i));
    lat_c = lat_x;
    lon_c = lon_x;
    if (lat_x > LAT_LIMIT) lat_c = LAT_LIMIT;
    if (lat_x < -LAT_LIMIT) lat_c = -LAT_LIMIT;
    if (lon_x > LON_LIMIT) lon_c = LON_LIMIT;
    if (lon_x < -LON_LIMIT) lon_c = -LON_LIMIT;
    lat_sum = lat_c + LAT_LIMIT;
    lon_sum = lon_c + LON_LIMIT;
    pipe_d[0].lon   = lon_sum[29:0];
    pipe_d[0].lat   = lat_sum[29:0];
    pipe_d[0].chars = '0;
  end

  for (genvar g = 1; g <= NUM_PAIRS; g++) begin : g_pair
    char_t  lon_char, lat_char;
    coord_t lon_rem, lat_rem;

    mhl_pair_div u_div (
      .pair_i     (pair_idx_t'(g - 1)),
      .lon_i      (pipe_q[g-1].lon),
      .lat_i      (pipe_q[g-1].lat),
      .lon_char_o (lon_char),
      .lat_char_o (lat_char),
      .lon_rem_o  (lon_rem),
      .lat_rem_o  (lat_rem)
    );

    always_comb begin
      pipe_d[g]                  = pipe_q[g-1];
      pipe_d[g].lon              = lon_rem;
      pipe_d[g].lat              = lat_rem;
      pipe_d[g].chars[2*(g-1)]   = lon_char;
      pipe_d[g].chars[2*(g-1)+1] = lat_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k <= NUM_PAIRS; k++) begin
        if (rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) pipe_q[0] <= pipe_d[0];
    for (int k = 1; k <= NUM_PAIRS; k++) begin
      if (rdy[k]) pipe_q[k] <= pipe_d[k];
    end
  end

  assign out_valid_o       = valid_q[NUM_PAIRS];
  assign char_field_lon_o  = pipe_q[NUM_PAIRS].chars[0];
  assign char_field_lat_o  = pipe_q[NUM_PAIRS].chars[1];
  assign char_square_lon_o = pipe_q[NUM_PAIRS].chars[2][5:0];
  assign char_square_lat_o = pipe_q[NUM_PAIRS].chars[3][5:0];
  assign char_subsq_lon_o  = pipe_q[NUM_PAIRS].chars[4];
  assign char_subsq_lat_o  = pipe_q[NUM_PAIRS].chars[5];
  assign char_ext_lon_o    = pipe_q[NUM_PAIRS].chars[6][5:0];
  assign char_ext_lat_o    = pipe_q[NUM_PAIRS].chars[7][5:0];
  assign char_fine_lon_o   = pipe_q[NUM_PAIRS].chars[8][5:0];
  assign char_fine_lat_o   = pipe_q[NUM_PAIRS].chars[9][5:0];

  // An empty output stage means every stage has room, so the input side must be open.
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NUM_PAIRS] |-> in_ready_o)
    else $error("input stalled although the output stage is empty");

  a_accept_fills_stage0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted beat did not reach the first stage");

  // After the last pair the leftover must be below the finest step.
  a_fine_remainder : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NUM_PAIRS] |-> (pipe_q[NUM_PAIRS].lon < 30'd2000)
                           && (pipe_q[NUM_PAIRS].lat < 30'd1000))
    else $error("remainder after the fine step is out of range");

  a_field_letter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_field_lon_o >= CHAR_A) && (char_field_lon_o <= 7'd83)
                    && (char_field_lat_o >= CHAR_A) && (char_field_lat_o <= 7'd83))
    else $error("field letter beyond S");

endmodule

FILE: rtl/mhl_pair_div.sv
// One locator character pair: quotient and remainder of longitude and latitude by a step.
// Depends on mhl_pkg for the step multiple tables and character codes.
module mhl_pair_div import mhl_pkg::*; (
  input  pair_idx_t pair_i,
  input  coord_t    lon_i,
  input  coord_t    lat_i,
  output char_t     lon_char_o,
  output char_t     lat_char_o,
  output coord_t    lon_rem_o,
  output coord_t    lat_rem_o
);

  quot_t    lim;
  quot_t    lon_q;
  quot_t    lat_q;
  mul_row_t lon_row;
  mul_row_t lat_row;

  // The quotient is the number of the first lm step multiples that do not exceed the
  // value; the comparisons are independent, so they run side by side.
  function automatic quot_t count_mult(input coord_t v, input mul_row_t row, input quot_t lm);
    logic [MAX_MULT-1:0] hits;
    for (int k = 0; k < MAX_MULT; k++) begin
      hits[k] = (5'(k) < lm) && ({2'b00, v} >= row[k]);
    end
    return 5'($countones(hits));
  endfunction

  function automatic coord_t take_rem(input coord_t v, input mul_row_t row, input quot_t q);
    logic [31:0] sub;
    sub = (q == 5'd0) ? 32'd0 : row[q - 5'd1];
    return v - sub[29:0];
  endfunction

  function automatic char_t encode(input quot_t q, input logic letter);
    return letter ? char_t'(CHAR_A + {2'b00, q}) : char_t'(CHAR_0 + {2'b00, q});
  endfunction

  assign lim     = PAIR_IS_LETTER[pair_i] ? LETTER_MAX_Q : DIGIT_MAX_Q;
  assign lon_row = LON_MUL[pair_i];
  assign lat_row = LAT_MUL[pair_i];

  assign lon_q = count_mult(lon_i, lon_row, lim);
  assign lat_q = count_mult(lat_i, lat_row, lim);

  assign lon_rem_o  = take_rem(lon_i, lon_row, lon_q);
  assign lat_rem_o  = take_rem(lat_i, lat_row, lat_q);
  assign lon_char_o = encode(lon_q, PAIR_IS_LETTER[pair_i]);
  assign lat_char_o = encode(lat_q, PAIR_IS_LETTER[pair_i]);

endmodule
